FILE: src/cllf_pkg.sv
// Shared types and constants for the crossing-locked loop freeze core.
// Depends on nothing; the control unit, output stage and top level in src import it.
`timescale 1ns / 1ps

package cllf_pkg;

  localparam int unsigned DEPTH      = 8192;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MINLEN_W   = 13;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MIN_FLOOR  = 8;

  localparam logic [ADDR_W-1:0] CNT_MAX = ADDR_W'(DEPTH - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd2;

  // input actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  localparam logic [MINLEN_W-1:0] MINLEN_RESET = 13'd128;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [1:0]                 event_res;
  } out_t;

  // beat handed from the control unit to the output stage
  typedef struct packed {
    logic                       use_mem;
    logic signed [SAMPLE_W-1:0] sample;
    logic [1:0]                 evt;
  } beat_t;

  typedef struct packed {
    logic recording;
    logic playing;
  } stat_t;

  function automatic logic [ADDR_W-1:0] clamp_len(input logic [MINLEN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(DEPTH - 1)) begin
      return CNT_MAX;
    end else if (w < 32'(MIN_FLOOR)) begin
      return ADDR_W'(MIN_FLOOR);
    end
    return ADDR_W'(w);
  endfunction

endpackage

FILE: src/crossing_locked_loop_freeze_core.sv
// Top level of the crossing-locked loop freeze core: control unit, loop
// store RAM and output pipeline. Uses cllf_pkg, cllf_ctrl, cllf_ram, cllf_ostage.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / in_i): one beat per audio sample
//   or record command. Output channel (out_valid_o / out_ready_i / out_o):
//   exactly one beat per input beat, in order.
//   Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i): threshold, fall mode,
//   min length; write only while idle. A write to any of these three drops the capture.
// Path: an accepted beat is held in the read-data stage, beside the loop-store
//   read data, and then in the output register.
// Throughput: one beat per cycle while out_ready_i is high. Each beat needs at
//   most one access to the 8192-entry loop store (a write while capturing, a
//   read while looping), done in the accept cycle.
// Reset: not capturing, not looping, threshold 0, rising mode, min length
//   128. The loop store is not cleared; only slots written in the current
//   capture are ever played.
// Stall: when out_ready_i is low, the output register and the read-data stage
//   each hold one beat; in_ready_o drops once both are full and the RAM read
//   data is held until the waiting beat moves on.

module crossing_locked_loop_freeze_core import cllf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_o
);

  logic                in_acc;
  logic                beat_vld;
  beat_t               beat;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  stat_t               stat;

  assign in_acc = in_valid_i && in_ready_o;

  cllf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (in_acc),
    .in_i        (in_i),
    .beat_vld_o  (beat_vld),
    .beat_o      (beat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .stat_o      (stat)
  );

  cllf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_loop_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cllf_ostage u_ostage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_vld_i  (beat_vld),
    .beat_i      (beat),
    .rdata_i     (ram_rdata),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  a_rec_play_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.recording && stat.playing))
    else $error("capture and loop playback active together");

  a_ram_one_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("loop store written and read in one cycle");

  a_ram_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we || ram_re) |-> in_acc)
    else $error("loop store accessed without an accepted beat");

  a_record_arms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i && in_i.action == ACT_RECORD) |=>
      (stat.recording && !stat.playing))
    else $error("record command did not arm the capture");

endmodule

FILE: src/cllf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cllf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cllf_ctrl.sv
// Capture control: crossing detection, capture counters, loop playback
// addressing and configuration registers. Uses cllf_pkg.
`timescale 1ns / 1ps

module cllf_ctrl import cllf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 acc_i,
  input  in_t                  in_i,
  output logic                 beat_vld_o,
  output beat_t                beat_o,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [SAMPLE_W-1:0]  ram_wdata_o,
  output logic                 ram_re_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  output stat_t                stat_o
);

  logic                       rec_q, rec_d;
  logic                       seek_q, seek_d;
  logic [ADDR_W-1:0]          cnt_q, cnt_d;
  logic                       play_q, play_d;
  logic [ADDR_W-1:0]          len_q, len_d;
  logic [ADDR_W-1:0]          pos_q, pos_d;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic                       prev_vld_q, prev_vld_d;
  logic signed [SAMPLE_W-1:0] thr_q, thr_d;
  logic                       fall_q, fall_d;
  logic [ADDR_W-1:0]          minl_q, minl_d;

  logic                       crossed;
  logic                       clr;
  logic                       seek_nxt;
  logic                       store;
  logic                       end_now;
  logic [ADDR_W-1:0]          raddr;
  logic [ADDR_W:0]            pos_nxt;
  logic [ADDR_W-1:0]          len_cur;
  logic signed [SAMPLE_W-1:0] a;

  assign a = in_i.sample_in;

  always_comb begin
    if (!prev_vld_q) begin
      crossed = 1'b0;
    end else if (fall_q) begin
      crossed = (a <= thr_q) && (prev_q > thr_q);
    end else begin
      crossed = (a > thr_q) && (prev_q <= thr_q);
    end
  end

  always_comb begin
    rec_d      = rec_q;
    seek_d     = seek_q;
    cnt_d      = cnt_q;
    play_d     = play_q;
    len_d      = len_q;
    pos_d      = pos_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    thr_d      = thr_q;
    fall_d     = fall_q;
    minl_d     = minl_q;
    clr        = 1'b0;
    seek_nxt   = seek_q;
    store      = 1'b0;
    end_now    = 1'b0;
    raddr      = pos_q;
    pos_nxt    = '0;
    len_cur    = len_q;
    ram_re_o   = 1'b0;
    beat_o.use_mem = 1'b0;
    beat_o.sample  = a;
    beat_o.evt     = EV_NONE;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: begin
          thr_d = cfg_wdata_i[SAMPLE_W-1:0];
          clr   = 1'b1;
        end
        REG_FALL_MODE: begin
          fall_d = cfg_wdata_i[0];
          clr    = 1'b1;
        end
        REG_MIN_LENGTH: begin
          minl_d = clamp_len(cfg_wdata_i[MINLEN_W-1:0]);
          clr    = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (acc_i) begin
      if (in_i.action == ACT_RECORD) begin
        rec_d         = 1'b1;
        clr           = 1'b1;
        beat_o.sample = '0;
        beat_o.evt    = EV_START;
      end else begin
        if (rec_q) begin
          seek_nxt = seek_q & ~crossed;
          seek_d   = seek_nxt;
          if (!seek_nxt) begin
            if ((cnt_q < minl_q) || !crossed) begin
              store = 1'b1;
            end else begin
              end_now = 1'b1;
            end
          end
          prev_d     = a;
          prev_vld_d = 1'b1;
        end
        if (store) begin
          cnt_d = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
        end
        if (end_now) begin
          rec_d      = 1'b0;
          play_d     = 1'b1;
          len_d      = cnt_q;
          beat_o.evt = EV_DONE;
        end
        // ending beat already plays slot zero
        if (play_q || end_now) begin
          raddr          = end_now ? '0 : pos_q;
          len_cur        = end_now ? cnt_q : len_q;
          pos_nxt        = {1'b0, raddr} + 1'b1;
          pos_d          = (pos_nxt >= {1'b0, len_cur}) ? '0 : pos_nxt[ADDR_W-1:0];
          ram_re_o       = 1'b1;
          beat_o.use_mem = 1'b1;
        end
      end
    end

    if (clr) begin
      cnt_d      = '0;
      seek_d     = 1'b1;
      play_d     = 1'b0;
      len_d      = '0;
      pos_d      = '0;
      prev_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q      <= 1'b0;
      seek_q     <= 1'b1;
      cnt_q      <= '0;
      play_q     <= 1'b0;
      len_q      <= '0;
      pos_q      <= '0;
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
      thr_q      <= '0;
      fall_q     <= 1'b0;
      minl_q     <= clamp_len(MINLEN_RESET);
    end else begin
      rec_q      <= rec_d;
      seek_q     <= seek_d;
      cnt_q      <= cnt_d;
      play_q     <= play_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
      thr_q      <= thr_d;
      fall_q     <= fall_d;
      minl_q     <= minl_d;
    end
  end

  assign beat_vld_o   = acc_i;
  assign ram_we_o     = store;
  assign ram_waddr_o  = cnt_q;
  assign ram_wdata_o  = a;
  assign ram_raddr_o  = raddr;
  assign stat_o.recording = rec_q;
  assign stat_o.playing   = play_q;

endmodule

FILE: src/cllf_ostage.sv
// Output pipeline: a read-data stage that waits for the RAM read data, then an
// output register toward the receiver. Uses cllf_pkg.
`timescale 1ns / 1ps

module cllf_ostage import cllf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_vld_i,
  input  beat_t               beat_i,
  input  logic [SAMPLE_W-1:0] rdata_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output out_t                out_o
);

  logic  s1_vld_q, s1_vld_d;
  beat_t s1_q;
  logic  s2_vld_q, s2_vld_d;
  out_t  s2_q;
  logic  s1_adv;
  out_t  s1_res;

  assign s1_adv     = s1_vld_q && (!s2_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;

  assign s1_res.sample_out = s1_q.use_mem ? rdata_i : s1_q.sample;
  assign s1_res.event_res  = s1_q.evt;

  always_comb begin
    s1_vld_d = s1_vld_q;
    s2_vld_d = s2_vld_q;
    if (out_ready_i) begin
      s2_vld_d = 1'b0;
    end
    if (s1_adv) begin
      s2_vld_d = 1'b1;
      s1_vld_d = 1'b0;
    end
    if (beat_vld_i) begin
      s1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_vld_i) begin
      s1_q <= beat_i;
    end
    if (s1_adv) begin
      s2_q <= s1_res;
    end
  end

  assign out_valid_o = s2_vld_q;
  assign out_o       = s2_q;

endmodule

FILE: tb/sv/crossing_locked_loop_freeze_checker.sv
`timescale 1ns / 1ps
// Scoreboard for crossing_locked_loop_freeze_core: follows register writes,
// predicts one output beat per input beat and compares them in order.
// Depends on cllf_pkg for beat types, event codes and register indexes.

module crossing_locked_loop_freeze_checker import cllf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  logic signed [SAMPLE_W-1:0] loop_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] thr;
  logic signed [SAMPLE_W-1:0] prev_smp;
  logic                       fall;
  logic                       capturing;
  logic                       seeking;
  logic                       looping;
  logic                       prev_ok;
  int unsigned                min_len;
  int unsigned                fill;
  int unsigned                loop_len;
  int unsigned                play_pos;
  out_t                       due_q [$];
  int unsigned                bad_beats;

  function automatic void drop_capture();
    fill     = 0;
    seeking  = 1'b1;
    looping  = 1'b0;
    loop_len = 0;
    play_pos = 0;
    prev_ok  = 1'b0;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    int unsigned len;
    len = data[MINLEN_W-1:0];
    case (idx)
      REG_THRESHOLD: thr = data;
      REG_FALL_MODE: fall = data[0];
      REG_MIN_LENGTH: begin
        if (len < MIN_FLOOR) len = MIN_FLOOR;
        if (len > DEPTH - 1) len = DEPTH - 1;
        min_len = len;
      end
      default: return;
    endcase
    drop_capture();
  endfunction

  function automatic logic crosses(logic signed [SAMPLE_W-1:0] smp);
    if (!prev_ok) return 1'b0;
    if (fall) return (smp <= thr) && (prev_smp > thr);
    return (smp > thr) && (prev_smp <= thr);
  endfunction

  function automatic void store_sample(logic signed [SAMPLE_W-1:0] smp);
    if (fill < DEPTH) loop_mem[fill] = smp;
    fill++;
  endfunction

  function automatic out_t freeze_next(in_t beat);
    out_t                       res;
    logic signed [SAMPLE_W-1:0] smp;
    res.event_res = EV_NONE;
    if (beat.action == ACT_RECORD) begin
      capturing = 1'b1;
      drop_capture();
      res.sample_out = '0;
      res.event_res  = EV_START;
      return res;
    end
    smp = beat.sample_in;
    if (capturing) begin
      if (seeking && crosses(smp)) seeking = 1'b0;
      if (!seeking) begin
        if (fill < min_len) begin
          store_sample(smp);
        end else if (crosses(smp)) begin
          // closing crossing is not stored; loop starts on this very beat
          capturing     = 1'b0;
          looping       = 1'b1;
          play_pos      = 0;
          loop_len      = fill;
          res.event_res = EV_DONE;
        end else begin
          store_sample(smp);
        end
        // hold the count on the last slot once the store is full
        if (fill >= DEPTH - 1) fill = DEPTH - 1;
      end
      prev_smp = smp;
      prev_ok  = 1'b1;
    end
    if (looping) begin
      res.sample_out = (play_pos < DEPTH) ? loop_mem[play_pos] : '0;
      play_pos++;
      if (play_pos >= loop_len) play_pos = 0;
    end else begin
      res.sample_out = smp;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      thr       = '0;
      fall      = 1'b0;
      min_len   = MINLEN_RESET;
      capturing = 1'b0;
      prev_smp  = '0;
      drop_capture();
      due_q.delete();
      bad_beats = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_wdata_i);
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("%0t: output beat with none due: sample_out %0d event %0d",
                     $realtime, out_i.sample_out, out_i.event_res);
          end
        end else begin
          want = due_q.pop_front();
          if (out_i.sample_out !== want.sample_out || out_i.event_res !== want.event_res) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("%0t: mismatch: sample_out exp %0d got %0d, event exp %0d got %0d",
                       $realtime, want.sample_out, out_i.sample_out,
                       want.event_res, out_i.event_res);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) due_q.push_back(freeze_next(in_i));
      fail_count_o <= bad_beats + due_q.size();
      pending_o    <= due_q.size();
    end
  end

endmodule

FILE: tb/sv/crossing_locked_loop_freeze_core_tb.sv
`timescale 1ns / 1ps
// Top of the loop freeze testbench: clock, reset, register writes, stream
// traffic with random gaps and stalls, and the verdict.
// Depends on cllf_pkg, crossing_locked_loop_freeze_core and the checker module.

module crossing_locked_loop_freeze_core_tb;
  import cllf_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS = 1200;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_o;
  int unsigned          fail_count;
  int unsigned          pending;

  logic signed [SAMPLE_W-1:0] thr_cfg     = '0;
  logic                       wave_high   = 1'b0;
  int unsigned                wave_left   = 0;
  int unsigned                seg_max     = 8;
  int unsigned                stall_left  = 0;
  int unsigned                idle_cycles = 0;
  bit                         calm        = 1'b0;

  always #5 clk_i = ~clk_i;

  crossing_locked_loop_freeze_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  crossing_locked_loop_freeze_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_i         (in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i        (out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 100);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // square-ish wave around the threshold, random segment lengths and levels
  function automatic int next_wave();
    if (wave_left == 0) begin
      wave_high = ~wave_high;
      wave_left = $urandom_range(1, seg_max);
    end
    wave_left--;
    if (wave_high && thr_cfg != 16'sh7FFF) return rand_between(int'(thr_cfg) + 1, 32767);
    return rand_between(-32768, int'(thr_cfg));
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_THRESHOLD) thr_cfg = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_beat(logic act, int smp);
    int unsigned gap;
    in_t         beat;
    gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.action    = act;
    beat.sample_in = smp[SAMPLE_W-1:0];
    in_valid_i <= 1'b1;
    in_i       <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // called right after the last accepted beat
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 35) begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned      rand_items;
    int unsigned      budget;
    int unsigned      n;
    int unsigned      len;
    int unsigned      phase;
    int unsigned      r;
    logic [CFG_W-1:0] word;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // min length below the floor, field extremes, restart while capturing,
    // a short capture, then restart while looping
    cfg_write(REG_MIN_LENGTH, '0);
    push_beat(ACT_SAMPLE, 32767);
    push_beat(ACT_SAMPLE, -32768);
    push_beat(ACT_RECORD, -1);
    push_beat(ACT_SAMPLE, 100);   // no previous sample yet
    push_beat(ACT_SAMPLE, -100);
    push_beat(ACT_RECORD, 0);
    push_beat(ACT_SAMPLE, 200);
    push_beat(ACT_SAMPLE, 0);
    push_beat(ACT_SAMPLE, 1);     // opens the capture
    push_beat(ACT_SAMPLE, 2);
    push_beat(ACT_SAMPLE, -3);
    push_beat(ACT_SAMPLE, 4);     // crossing below min length: stored
    push_beat(ACT_SAMPLE, -5);
    push_beat(ACT_SAMPLE, 6);
    push_beat(ACT_SAMPLE, -7);
    push_beat(ACT_SAMPLE, 8);
    push_beat(ACT_SAMPLE, -9);
    push_beat(ACT_SAMPLE, 10);    // closes the capture
    push_beat(ACT_SAMPLE, 11);
    push_beat(ACT_SAMPLE, -12);
    push_beat(ACT_SAMPLE, 13);
    push_beat(ACT_RECORD, 0);
    push_beat(ACT_SAMPLE, 5);
    drain();

    phase      = 1;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      calm    = ($urandom_range(0, 3) == 0);
      seg_max = $urandom_range(2, 24);
      case (phase)
        1: begin
          cfg_write(REG_THRESHOLD, 16'h8000);
          cfg_write(REG_FALL_MODE, CFG_W'(1));
          cfg_write(REG_MIN_LENGTH, CFG_W'(5));
        end
        2: begin
          cfg_write(REG_THRESHOLD, 16'h7FFF);
          cfg_write(REG_FALL_MODE, '0);
          cfg_write(REG_MIN_LENGTH, CFG_W'(20));
        end
        3: begin
          cfg_write(REG_THRESHOLD, 16'h8000);
          cfg_write(REG_MIN_LENGTH, CFG_W'(8));
        end
        4: begin
          // oversized min length clamps to one below the store size: the capture stays open
          cfg_write(REG_THRESHOLD, '0);
          cfg_write(REG_FALL_MODE, '0);
          cfg_write(REG_MIN_LENGTH, 16'hFFFF);
          push_beat(ACT_RECORD, 0);
          push_beat(ACT_SAMPLE, -1);
          repeat (60) push_beat(ACT_SAMPLE, $urandom_range(1, 32767));
          push_beat(ACT_SAMPLE, -5);
          push_beat(ACT_SAMPLE, 7);
          repeat (40) push_beat(ACT_SAMPLE, $urandom);
          rand_items += 104;
        end
        default: begin
          if ($urandom_range(0, 99) < 60) begin
            r = $urandom_range(0, 4);
            if (r == 0) word = 16'h8000;
            else if (r == 1) word = 16'h7FFF;
            else if (r == 4) word = CFG_W'($urandom);
            else word = CFG_W'(rand_between(-1000, 1000));
            cfg_write(REG_THRESHOLD, word);
          end
          if ($urandom_range(0, 99) < 50) cfg_write(REG_FALL_MODE, CFG_W'($urandom_range(0, 1)));
          if ($urandom_range(0, 99) < 60) begin
            r = $urandom_range(0, 99);
            if (r < 75) word = CFG_W'($urandom_range(8, 48));
            else if (r < 90) word = CFG_W'($urandom_range(0, 7));
            else word = CFG_W'($urandom);
            cfg_write(REG_MIN_LENGTH, word);
          end
        end
      endcase
      if (phase != 4) begin
        budget = $urandom_range(100, 160);
        n      = 0;
        while (n < budget) begin
          if ($urandom_range(0, 99) < 80) begin
            len = $urandom_range(10, 120);
            push_beat(ACT_RECORD, $urandom);
            repeat (len) push_beat(ACT_SAMPLE, next_wave());
            n += len + 1;
          end else begin
            len = $urandom_range(5, 20);
            repeat (len) begin
              push_beat(($urandom_range(0, 19) == 0) ? ACT_RECORD : ACT_SAMPLE, $urandom);
            end
            n += len;
          end
        end
        rand_items += n;
      end
      drain();
      phase++;
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
